// ===== rtl/core/ss_pkg.sv =====
// Shared types and constants for the stride scheduler.
// No dependencies; every other file imports this package.
package ss_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam int OPC_W     = 3;
  localparam int SLOT_W    = 4;
  localparam int PRIO_W    = 16;
  localparam int STRIDE_W  = 32;
  localparam int STATUS_W  = 2;

  localparam int DIV_CNT_W = $clog2(STRIDE_W);

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [STRIDE_W-1:0] STRIDE_BASE_RESET = 32'd65536;
  localparam logic [PRIO_W-1:0]   PRIO_AT_INIT      = 16'd16;
  localparam logic [PRIO_W-1:0]   PRIO_MIN          = 16'd2;

  localparam logic [OPC_W-1:0] OP_INIT = 3'd0;
  localparam logic [OPC_W-1:0] OP_RUN  = 3'd1;
  localparam logic [OPC_W-1:0] OP_STOP = 3'd2;
  localparam logic [OPC_W-1:0] OP_SETP = 3'd3;
  localparam logic [OPC_W-1:0] OP_PICK = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_INIT,
    CMD_RUN,
    CMD_STOP,
    CMD_SETP,
    CMD_REJECT,
    CMD_PICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [PRIO_W-1:0]  prio;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

// ===== rtl/core/ss_if.sv =====
// Handshake channels of the stride scheduler: request, response and configuration.
// Depends on ss_pkg for the field widths.
interface ss_req_if import ss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPC_W-1:0]    opcode;
  logic [SLOT_W-1:0]   slot;
  logic [PRIO_W-1:0]   priority_value;

  modport source (output valid, output opcode, output slot, output priority_value,
                  input ready);
  modport sink   (input valid, input opcode, input slot, input priority_value,
                  output ready);
endinterface

interface ss_rsp_if import ss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   chosen_slot;

  modport source (output valid, output status, output chosen_slot, input ready);
  modport sink   (input valid, input status, input chosen_slot, output ready);
endinterface

interface ss_cfg_if import ss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STRIDE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/stride_scheduler.sv =====
// Stride scheduler: init, run, stop, set-priority and pick over NUM_SLOTS task slots.
// A table command's result is registered when the engine dequeues it. A pick dequeues,
// scans all NUM_SLOTS slots, fetches the priority and loads the divider, then runs the
// bit-serial divide.
// One item runs at a time, the next once the result is taken; two more may queue.
// Synchronous reset: all slots not runnable, pass 0, priority 16; stride base 65536.
module stride_scheduler import ss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ss_req_if.sink   req,
  ss_rsp_if.source rsp,
  ss_cfg_if.sink   cfg
);

  cmd_t    q_wr;
  cmd_t    q_rd;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    busy;

  ss_front u_front (
    .req    (req),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (q_wr)
  );

  ss_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (q_wr),
    .pop    (pop),
    .rd_cmd (q_rd),
    .stat   (q_stat)
  );

  ss_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (q_rd),
    .q_stat (q_stat),
    .pop    (pop),
    .rsp    (rsp),
    .busy   (busy)
  );

  // A pick in flight never coexists with a waiting result.
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    busy |-> !rsp.valid)
    else $error("engine busy while a result is pending");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> rsp.chosen_slot == '0)
    else $error("failed item reports a chosen slot");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid && !busy)
    else $error("engine not idle after reset");

endmodule

// ===== rtl/core/ss_front.sv =====
// Front end: accepts request items and classifies them into table commands.
// Depends on ss_pkg and ss_req_if.
module ss_front import ss_pkg::*; (
  ss_req_if.sink  req,
  input  q_stat_t q_stat,
  output logic    push,
  output cmd_t    cmd
);

  logic in_range;

  assign req.ready = !q_stat.full;
  assign push      = req.valid && !q_stat.full;
  assign in_range  = 32'(req.slot) < 32'(NUM_SLOTS);

  always_comb begin
    cmd.idx  = IDX_W'(req.slot);
    cmd.prio = req.priority_value;
    unique case (req.opcode)
      OP_INIT: cmd.kind = in_range ? CMD_INIT : CMD_NOP;
      OP_RUN:  cmd.kind = in_range ? CMD_RUN : CMD_NOP;
      OP_STOP: cmd.kind = in_range ? CMD_STOP : CMD_NOP;
      OP_SETP: begin
        // The priority check wins over the slot range check.
        if (req.priority_value < PRIO_MIN) cmd.kind = CMD_REJECT;
        else if (in_range)                 cmd.kind = CMD_SETP;
        else                               cmd.kind = CMD_NOP;
      end
      OP_PICK: cmd.kind = CMD_PICK;
      default: cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/core/ss_cmd_fifo.sv =====
// Short command queue between the front end and the slot table engine.
// Depends on ss_pkg.
module ss_cmd_fifo import ss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    rd_cmd,
  output q_stat_t stat
);

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign rd_cmd         = entries[rd_ptr];
  assign stat.not_empty = count != '0;
  assign stat.full      = count == Q_CNT_W'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

endmodule

// ===== rtl/core/ss_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ss_pkg. A zero divisor yields a zero quotient.
module ss_div import ss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [STRIDE_W-1:0] dividend,
  input  logic [PRIO_W-1:0]   divisor,
  output logic                done,
  output logic [STRIDE_W-1:0] quotient
);

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [STRIDE_W-1:0]  dq;
  logic [PRIO_W-1:0]    rem;
  logic [PRIO_W-1:0]    dsr;
  logic                 zdiv;
  logic [PRIO_W:0]      trial;
  logic                 ge;

  assign trial    = {rem, dq[STRIDE_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = zdiv ? '0 : dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(STRIDE_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq   <= dividend;
      rem  <= '0;
      dsr  <= divisor;
      zdiv <= divisor == '0;
    end else if (run) begin
      rem <= ge ? PRIO_W'(trial - {1'b0, dsr}) : trial[PRIO_W-1:0];
      dq  <= {dq[STRIDE_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/ss_back.sv =====
// Slot table engine: executes queued commands, scans for the least pass value
// and advances the granted slot. Depends on ss_pkg, ss_if and ss_div.
module ss_back import ss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  ss_cfg_if.sink  cfg,
  input  cmd_t    cmd,
  input  q_stat_t q_stat,
  output logic    pop,
  ss_rsp_if.source rsp,
  output logic    busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PRIO  = 5'b00100,
    S_START = 5'b01000,
    S_DIV   = 5'b10000
  } state_t;

  state_t state;

  logic [STRIDE_W-1:0]  stride_base;

  // Per-slot flags; an entry whose valid bit is clear reads as its reset value.
  logic [NUM_SLOTS-1:0] runnable;
  logic [NUM_SLOTS-1:0] pass_valid;
  logic [NUM_SLOTS-1:0] prio_valid;

  logic [STRIDE_W-1:0]  pass_mem [NUM_SLOTS];
  logic [PRIO_W-1:0]    prio_mem [NUM_SLOTS];

  logic [CNT_W-1:0]     scan_cnt;
  logic [IDX_W-1:0]     scan_addr;
  logic                 cmp_live;
  logic [IDX_W-1:0]     cmp_idx;
  logic [STRIDE_W-1:0]  pass_q;
  logic                 pv_q;
  logic [PRIO_W-1:0]    prio_q;
  logic                 prio_vq;

  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [STRIDE_W-1:0]  best_pass;

  logic [STRIDE_W-1:0]  eff_pass;
  logic                 take;
  logic                 scan_last;
  logic                 div_start;
  logic                 div_done;
  logic [PRIO_W-1:0]    divisor;
  logic [STRIDE_W-1:0]  quotient;
  logic [STRIDE_W-1:0]  pass_new;
  logic                 pass_we;
  logic                 prio_we;

  logic                 res_valid;
  logic [STATUS_W-1:0]  res_status;
  logic [SLOT_W-1:0]    res_chosen;

  assign cfg.ready       = 1'b1;
  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.chosen_slot = res_chosen;
  assign busy            = state != S_IDLE;

  always_comb begin
    pop       = (state == S_IDLE) && q_stat.not_empty && !res_valid;
    scan_addr = scan_cnt[IDX_W-1:0];
    eff_pass  = pv_q ? pass_q : '0;
    take      = cmp_live && runnable[cmp_idx] && (!found || eff_pass < best_pass);
    scan_last = cmp_live && (cmp_idx == IDX_W'(NUM_SLOTS - 1));
    div_start = state == S_START;
    divisor   = prio_vq ? prio_q : PRIO_AT_INIT;
    pass_new  = best_pass + quotient;
    pass_we   = (state == S_DIV) && div_done;
    prio_we   = pop && (cmd.kind == CMD_SETP);
  end

  ss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (stride_base),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_base <= STRIDE_BASE_RESET;
    end else if (cfg.valid) begin
      stride_base <= cfg.data;
    end
  end

  // Table memories: one write and one registered read per array each cycle.
  always_ff @(posedge clk) begin
    pass_q  <= pass_mem[scan_addr];
    pv_q    <= pass_valid[scan_addr];
    prio_q  <= prio_mem[best_idx];
    prio_vq <= prio_valid[best_idx];
    if (pass_we) pass_mem[best_idx] <= pass_new;
    if (prio_we) prio_mem[cmd.idx] <= cmd.prio;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      runnable   <= '0;
      pass_valid <= '0;
      prio_valid <= '0;
      scan_cnt   <= '0;
      cmp_live   <= 1'b0;
      cmp_idx    <= '0;
      found      <= 1'b0;
      best_idx   <= '0;
      best_pass  <= '0;
      res_valid  <= 1'b0;
      res_status <= ST_OK;
      res_chosen <= '0;
    end else begin
      if (rsp.valid && rsp.ready) res_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (pop) begin
            res_chosen <= '0;
            res_status <= (cmd.kind == CMD_REJECT) ? ST_REJECT : ST_OK;
            res_valid  <= cmd.kind != CMD_PICK;
            unique case (cmd.kind)
              CMD_INIT: begin
                runnable[cmd.idx]   <= 1'b0;
                pass_valid[cmd.idx] <= 1'b0;
                prio_valid[cmd.idx] <= 1'b0;
              end
              CMD_RUN:    runnable[cmd.idx] <= 1'b1;
              CMD_STOP:   runnable[cmd.idx] <= 1'b0;
              CMD_SETP:   prio_valid[cmd.idx] <= 1'b1;
              CMD_PICK: begin
                scan_cnt <= '0;
                cmp_live <= 1'b0;
                found    <= 1'b0;
                state    <= S_SCAN;
              end
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          // Each read is registered, and its compare comes in the cycle after it.
          if (scan_cnt < CNT_W'(NUM_SLOTS)) begin
            scan_cnt <= scan_cnt + 1'b1;
            cmp_live <= 1'b1;
            cmp_idx  <= scan_addr;
          end else begin
            cmp_live <= 1'b0;
          end
          if (take) begin
            found     <= 1'b1;
            best_idx  <= cmp_idx;
            best_pass <= eff_pass;
          end
          if (scan_last) begin
            if (found || take) begin
              state <= S_PRIO;
            end else begin
              res_valid  <= 1'b1;
              res_status <= ST_EMPTY;
              res_chosen <= '0;
              state      <= S_IDLE;
            end
          end
        end

        S_PRIO:  state <= S_START;
        S_START: state <= S_DIV;

        S_DIV: begin
          if (div_done) begin
            runnable[best_idx]   <= 1'b0;
            pass_valid[best_idx] <= 1'b1;
            res_valid            <= 1'b1;
            res_status           <= ST_OK;
            res_chosen           <= SLOT_W'(best_idx);
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stride_scheduler: directed and random table commands and picks.
// Needs ss_pkg and the ss_req_if, ss_rsp_if and ss_cfg_if interfaces from the RTL.
module tb_top import ss_pkg::*; ();

  localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int NUM_PHASES = 5;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [OPC_W-1:0]  opcode;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio_val;
  } sched_op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   chosen_slot;
    logic                pick;
  } grant_t;

  logic clk = 1'b0;
  logic rst;

  ss_req_if req_ch();
  ss_rsp_if rsp_ch();
  ss_cfg_if cfg_ch();

  stride_scheduler dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the slot table and of the stride base.
  logic                sched_runnable [NUM_SLOTS];
  logic [STRIDE_W-1:0] sched_pass     [NUM_SLOTS];
  logic [PRIO_W-1:0]   sched_prio     [NUM_SLOTS];
  logic [STRIDE_W-1:0] sched_stride_base;

  sched_op_t pending_ops[$];
  grant_t    expected_grants[$];
  sched_op_t accepted_op;
  sched_op_t next_op;
  grant_t    oldest_grant;

  logic steady;
  int   mismatches = 0;
  int   ops_accepted = 0;
  int   grants_seen = 0;
  int   empty_picks = 0;
  int   rejects_seen = 0;
  int   stride_writes = 0;
  int   cycle_count = 0;

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic grant_t predict_grant(sched_op_t op);
    grant_t              res;
    int                  best;
    logic                in_range;
    logic [STRIDE_W-1:0] incr;
    res.status      = ST_OK;
    res.chosen_slot = '0;
    res.pick        = (op.opcode == OP_PICK);
    best            = -1;
    in_range        = (int'(op.slot) < NUM_SLOTS);
    case (op.opcode)
      OP_INIT: begin
        if (in_range) begin
          sched_runnable[op.slot] = 1'b0;
          sched_pass[op.slot]     = '0;
          sched_prio[op.slot]     = PRIO_AT_INIT;
        end
      end
      OP_RUN: begin
        if (in_range) sched_runnable[op.slot] = 1'b1;
      end
      OP_STOP: begin
        if (in_range) sched_runnable[op.slot] = 1'b0;
      end
      OP_SETP: begin
        // The priority floor is checked before the slot range.
        if (op.prio_val < PRIO_MIN) res.status = ST_REJECT;
        else if (in_range) sched_prio[op.slot] = op.prio_val;
      end
      OP_PICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (sched_runnable[i] && (best < 0 || sched_pass[i] < sched_pass[best])) best = i;
        end
        if (best < 0) begin
          res.status = ST_EMPTY;
        end else begin
          incr = (sched_prio[best] != '0) ?
                 sched_stride_base / {{(STRIDE_W-PRIO_W){1'b0}}, sched_prio[best]} : '0;
          sched_runnable[best] = 1'b0;
          sched_pass[best]     = sched_pass[best] + incr;
          res.chosen_slot      = best[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic sched_op_t random_op();
    sched_op_t op;
    int        roll;
    int        sub;
    op.opcode   = OP_RUN;
    op.slot     = SLOT_W'($urandom_range(0, 15));
    op.prio_val = PRIO_W'($urandom_range(0, 65535));
    roll        = $urandom_range(0, 99);
    sub         = $urandom_range(0, 99);
    if (roll < 30) begin
      op.opcode = OP_RUN;
    end else if (roll < 56) begin
      op.opcode = OP_PICK;
    end else if (roll < 70) begin
      op.opcode = OP_SETP;
      // Mostly legal priorities, with small ones so the increments stay coarse.
      if (sub < 10) op.prio_val = PRIO_W'($urandom_range(0, 1));
      else if (sub < 55) op.prio_val = PRIO_W'($urandom_range(2, 24));
      else op.prio_val = PRIO_W'($urandom_range(2, 65535));
    end else if (roll < 79) begin
      op.opcode = OP_STOP;
    end else if (roll < 86) begin
      op.opcode = OP_INIT;
    end else if (roll < 91) begin
      op.opcode = OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    return op;
  endfunction

  task automatic queue_op(logic [OPC_W-1:0] opcode, logic [SLOT_W-1:0] slot,
                          logic [PRIO_W-1:0] prio_val);
    sched_op_t op;
    op.opcode   = opcode;
    op.slot     = slot;
    op.prio_val = prio_val;
    pending_ops.push_back(op);
  endtask

  // Holds the sender until every queued item is accepted and every result is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || req_ch.valid || expected_grants.size() != 0);
  endtask

  task automatic write_stride_base(logic [STRIDE_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid      <= 1'b0;
    sched_stride_base  = value;
    stride_writes++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        accepted_op.opcode   = req_ch.opcode;
        accepted_op.slot     = req_ch.slot;
        accepted_op.prio_val = req_ch.priority_value;
        expected_grants.push_back(predict_grant(accepted_op));
        ops_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_ops.size() != 0 && (steady || $urandom_range(0, 99) >= 13)) begin
          next_op = pending_ops.pop_front();
          req_ch.valid          <= 1'b1;
          req_ch.opcode         <= next_op.opcode;
          req_ch.slot           <= next_op.slot;
          req_ch.priority_value <= next_op.prio_val;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_grants.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: status %0d slot %0d",
                                  rsp_ch.status, rsp_ch.chosen_slot));
        end else begin
          oldest_grant = expected_grants.pop_front();
          if (rsp_ch.status !== oldest_grant.status)
            flag_mismatch($sformatf("status %0d, expected %0d",
                                    rsp_ch.status, oldest_grant.status));
          if (rsp_ch.chosen_slot !== oldest_grant.chosen_slot)
            flag_mismatch($sformatf("chosen_slot %0d, expected %0d",
                                    rsp_ch.chosen_slot, oldest_grant.chosen_slot));
          if (oldest_grant.status == ST_EMPTY) empty_picks++;
          else if (oldest_grant.status == ST_REJECT) rejects_seen++;
          else if (oldest_grant.pick) grants_seen++;
        end
      end
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [STRIDE_W-1:0] stride_plan [NUM_PHASES];
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_INIT;
    req_ch.slot           = '0;
    req_ch.priority_value = '0;
    rsp_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.data           = '0;
    steady                = 1'b0;
    sched_stride_base     = STRIDE_BASE_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sched_runnable[i] = 1'b0;
      sched_pass[i]     = '0;
      sched_prio[i]     = PRIO_AT_INIT;
    end
    stride_plan[0] = 32'd1;
    stride_plan[1] = 32'hFFFF_FFFF;
    stride_plan[2] = 32'd0;
    stride_plan[3] = $urandom;
    stride_plan[4] = STRIDE_BASE_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset value of the stride base.
    queue_op(OP_PICK, 4'd0, 16'd0);            // nothing runnable yet
    queue_op(OP_RUN,  4'd15, 16'hFFFF);
    queue_op(OP_RUN,  4'd0, 16'd0);
    queue_op(OP_PICK, 4'd0, 16'd0);            // equal pass values go to the lower slot
    queue_op(OP_PICK, 4'd0, 16'd0);
    queue_op(OP_PICK, 4'd0, 16'd0);
    queue_op(OP_SETP, 4'd15, 16'd0);           // below the priority floor
    queue_op(OP_SETP, 4'd15, 16'd1);
    queue_op(OP_SETP, 4'd15, 16'hFFFF);
    queue_op(OP_SETP, 4'd0, 16'd2);
    queue_op(OP_SETP, 4'd7, 16'hAAAA);
    queue_op(OP_SETP, 4'd8, 16'h5555);
    queue_op(OP_RUN,  4'd0, 16'd0);
    queue_op(OP_RUN,  4'd15, 16'd0);
    queue_op(OP_PICK, 4'd0, 16'd0);
    queue_op(OP_PICK, 4'd0, 16'd0);
    queue_op(OP_RUN,  4'd5, 16'd0);
    queue_op(OP_STOP, 4'd5, 16'd0);
    queue_op(OP_PICK, 4'd0, 16'd0);
    queue_op(OP_RUN,  4'd0, 16'd0);
    queue_op(OP_INIT, 4'd0, 16'hFFFF);         // init also drops the runnable flag
    queue_op(OP_PICK, 4'd0, 16'd0);
    queue_op(OP_SPARE_LO, 4'd15, 16'hFFFF);
    queue_op(OP_SPARE_LO + 3'd1, 4'd0, 16'd0);
    queue_op(OP_SPARE_HI, 4'd15, 16'hFFFF);

    // Each phase drains fully before the stride base is rewritten.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_stride_base(stride_plan[p]);
      @(negedge clk);
      steady = (p == 2);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_ops.push_back(random_op());
    end

    wait_drained();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_grants.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_grants.size()));

    $display("Covered %0d items over %0d stride base settings including 0, 1 and all ones.",
             ops_accepted, stride_writes + 1);
    $display("Saw %0d grants, %0d empty picks, %0d rejected priorities; %0d mismatches.",
             grants_seen, empty_picks, rejects_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
